FILE: src/ntc_r2t_pkg.sv
// ----------------------------------------------------------------------------
// ntc_r2t_pkg
// shared types, microcode fields and the thermistor table for the
// resistance-to-temperature core
// ----------------------------------------------------------------------------
`default_nettype none

package ntc_r2t_pkg;

    // fixed field widths
    localparam int unsigned OHM_W     = 16;
    localparam int unsigned OUT_W     = 15;
    localparam int unsigned IDX_MAX_W = 6;   // table index, up to 64 entries
    localparam int unsigned DEG_W     = 9;   // 63 * 5 = 315 degrees
    localparam int unsigned GAP5_W    = 19;  // five times a 16-bit gap
    localparam int unsigned ROM_POINTS  = 21;
    localparam int unsigned DEGREE_STEP = 5;

    // microcode step index
    localparam int unsigned STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_FETCH  = 3'd0;
    localparam step_t STEP_TOP    = 3'd1;
    localparam step_t STEP_BOTTOM = 3'd2;
    localparam step_t STEP_SEARCH = 3'd3;
    localparam step_t STEP_PREP   = 3'd4;
    localparam step_t STEP_DIV    = 3'd5;
    localparam step_t STEP_SUM    = 3'd6;
    localparam step_t STEP_EMIT   = 3'd7;

    // datapath operation
    typedef enum logic [3:0] {
        OP_LOAD,
        OP_SET_TOP,
        OP_SET_ZERO,
        OP_HALVE,
        OP_PREP,
        OP_DIV,
        OP_SUM,
        OP_EMIT
    } op_t;

    // which table entry the compare flags look at
    typedef enum logic [1:0] {
        A_LAST,
        A_ZERO,
        A_MID
    } asel_t;

    // jump condition
    typedef enum logic [2:0] {
        C_NEVER,
        C_NO_IN,
        C_LE,
        C_GE,
        C_SEARCH,
        C_FLAT,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        asel_t asel;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic no_in;
        logic le;
        logic ge;
        logic search;
        logic flat;
        logic div_more;
        logic out_busy;
    } flags_t;

    // resistance table, entry i belongs to 5*i degrees; past the end reads 0
    function automatic logic [OHM_W-1:0] rom_ohms(input logic [IDX_MAX_W-1:0] idx);
        logic [OHM_W-1:0] v;
        case (idx)
            6'd0:    v = 16'd27380;
            6'd1:    v = 16'd22130;
            6'd2:    v = 16'd17980;
            6'd3:    v = 16'd14700;
            6'd4:    v = 16'd12090;
            6'd5:    v = 16'd10000;
            6'd6:    v = 16'd8311;
            6'd7:    v = 16'd6942;
            6'd8:    v = 16'd5825;
            6'd9:    v = 16'd4910;
            6'd10:   v = 16'd4157;
            6'd11:   v = 16'd3534;
            6'd12:   v = 16'd3017;
            6'd13:   v = 16'd2586;
            6'd14:   v = 16'd2225;
            6'd15:   v = 16'd1923;
            6'd16:   v = 16'd1667;
            6'd17:   v = 16'd1450;
            6'd18:   v = 16'd1265;
            6'd19:   v = 16'd1106;
            6'd20:   v = 16'd971;
            default: v = '0;
        endcase
        return v;
    endfunction

    // degrees of a table point: idx * 5
    function automatic logic [DEG_W-1:0] point_deg(input logic [IDX_MAX_W-1:0] idx);
        logic [DEG_W-1:0] x;
        x = DEG_W'(idx);
        return (x << 2) + x;
    endfunction

endpackage

`default_nettype wire

FILE: src/ntc_r2t_seq.sv
// ----------------------------------------------------------------------------
// ntc_r2t_seq
// microprogram store and step counter with conditional jumps
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_r2t_seq (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ntc_r2t_pkg::flags_t  flags,
    output ntc_r2t_pkg::ctrl_t        ctrl
);

    ntc_r2t_pkg::step_t upc_reg;
    ntc_r2t_pkg::step_t upc_next;
    logic               take_jump;

    // control store
    always_comb begin
        ctrl.op     = ntc_r2t_pkg::OP_EMIT;
        ctrl.asel   = ntc_r2t_pkg::A_MID;
        ctrl.cond   = ntc_r2t_pkg::C_OUT_BUSY;
        ctrl.target = ntc_r2t_pkg::STEP_EMIT;
        case (upc_reg)
            ntc_r2t_pkg::STEP_FETCH: begin
                ctrl.op     = ntc_r2t_pkg::OP_LOAD;
                ctrl.cond   = ntc_r2t_pkg::C_NO_IN;
                ctrl.target = ntc_r2t_pkg::STEP_FETCH;
            end
            ntc_r2t_pkg::STEP_TOP: begin
                ctrl.op     = ntc_r2t_pkg::OP_SET_TOP;
                ctrl.asel   = ntc_r2t_pkg::A_LAST;
                ctrl.cond   = ntc_r2t_pkg::C_LE;
                ctrl.target = ntc_r2t_pkg::STEP_EMIT;
            end
            ntc_r2t_pkg::STEP_BOTTOM: begin
                ctrl.op     = ntc_r2t_pkg::OP_SET_ZERO;
                ctrl.asel   = ntc_r2t_pkg::A_ZERO;
                ctrl.cond   = ntc_r2t_pkg::C_GE;
                ctrl.target = ntc_r2t_pkg::STEP_EMIT;
            end
            ntc_r2t_pkg::STEP_SEARCH: begin
                ctrl.op     = ntc_r2t_pkg::OP_HALVE;
                ctrl.cond   = ntc_r2t_pkg::C_SEARCH;
                ctrl.target = ntc_r2t_pkg::STEP_SEARCH;
            end
            ntc_r2t_pkg::STEP_PREP: begin
                ctrl.op     = ntc_r2t_pkg::OP_PREP;
                ctrl.cond   = ntc_r2t_pkg::C_FLAT;
                ctrl.target = ntc_r2t_pkg::STEP_EMIT;
            end
            ntc_r2t_pkg::STEP_DIV: begin
                ctrl.op     = ntc_r2t_pkg::OP_DIV;
                ctrl.cond   = ntc_r2t_pkg::C_DIV_MORE;
                ctrl.target = ntc_r2t_pkg::STEP_DIV;
            end
            ntc_r2t_pkg::STEP_SUM: begin
                ctrl.op     = ntc_r2t_pkg::OP_SUM;
                ctrl.cond   = ntc_r2t_pkg::C_NEVER;
                ctrl.target = ntc_r2t_pkg::STEP_FETCH;
            end
            default: begin
                // emit, falls through to fetch by wrap-around
                ctrl.op     = ntc_r2t_pkg::OP_EMIT;
                ctrl.cond   = ntc_r2t_pkg::C_OUT_BUSY;
                ctrl.target = ntc_r2t_pkg::STEP_EMIT;
            end
        endcase
    end

    always_comb begin
        case (ctrl.cond)
            ntc_r2t_pkg::C_NEVER:    take_jump = 1'b0;
            ntc_r2t_pkg::C_NO_IN:    take_jump = flags.no_in;
            ntc_r2t_pkg::C_LE:       take_jump = flags.le;
            ntc_r2t_pkg::C_GE:       take_jump = flags.ge;
            ntc_r2t_pkg::C_SEARCH:   take_jump = flags.search;
            ntc_r2t_pkg::C_FLAT:     take_jump = flags.flat;
            ntc_r2t_pkg::C_DIV_MORE: take_jump = flags.div_more;
            ntc_r2t_pkg::C_OUT_BUSY: take_jump = flags.out_busy;
            default:                 take_jump = 1'b0;
        endcase
        upc_next = take_jump ? ctrl.target : ntc_r2t_pkg::step_t'(upc_reg + 1'b1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= ntc_r2t_pkg::STEP_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ntc_r2t_datapath.sv
// ----------------------------------------------------------------------------
// ntc_r2t_datapath
// search bounds, table lookup, restoring divider and output register
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_r2t_datapath #(
    parameter int unsigned TABLE_ENTRIES = 21,
    parameter int unsigned FRACTION_BITS = 8
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire ntc_r2t_pkg::ctrl_t                  ctrl,
    output ntc_r2t_pkg::flags_t                      flags,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ntc_r2t_pkg::OHM_W-1:0]       s_resistance_ohms,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ntc_r2t_pkg::OUT_W-1:0]            m_temperature_q8
);

    localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
    localparam int unsigned QW    = FRACTION_BITS + 3;
    localparam int unsigned CNT_W = $clog2(QW + 1);
    localparam int unsigned REM_W = ntc_r2t_pkg::GAP5_W + FRACTION_BITS;
    localparam int unsigned TSW   = ntc_r2t_pkg::DEG_W + FRACTION_BITS;
    localparam int unsigned OHM_W = ntc_r2t_pkg::OHM_W;
    localparam int unsigned OUT_W = ntc_r2t_pkg::OUT_W;
    localparam int unsigned IMW   = ntc_r2t_pkg::IDX_MAX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic [OHM_W-1:0] r_reg;
    logic [IDX_W-1:0] lo_reg;
    logic [IDX_W-1:0] hi_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] dsh_reg;
    logic [QW-1:0]    q_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [OUT_W-1:0] res_reg;
    logic             m_valid_reg;
    logic [OUT_W-1:0] m_temp_reg;

    logic [IDX_W:0]   lohi_sum;
    logic [IDX_W-1:0] mid;
    logic [IDX_W-1:0] sel_idx;
    logic [OHM_W-1:0] sel_ohms;
    logic [OHM_W-1:0] lo_ohms;
    logic [OHM_W-1:0] hi_ohms;
    logic [OHM_W-1:0] den;
    logic [OHM_W-1:0] gap;
    logic [ntc_r2t_pkg::GAP5_W-1:0] gap5;
    logic [REM_W-1:0] rem_init;
    logic [REM_W-1:0] dsh_init;
    logic             rem_ge;
    logic [TSW-1:0]   top_wide;
    logic [TSW-1:0]   lo_wide;
    logic [OUT_W-1:0] top_q;
    logic [OUT_W-1:0] lo_q;
    logic             accept;

    always_comb begin
        lohi_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid      = lohi_sum[IDX_W:1];
        case (ctrl.asel)
            ntc_r2t_pkg::A_LAST: sel_idx = LAST_IDX;
            ntc_r2t_pkg::A_ZERO: sel_idx = '0;
            default:             sel_idx = mid;
        endcase
        sel_ohms = ntc_r2t_pkg::rom_ohms(IMW'(sel_idx));
        lo_ohms  = ntc_r2t_pkg::rom_ohms(IMW'(lo_reg));
        hi_ohms  = ntc_r2t_pkg::rom_ohms(IMW'(hi_reg));

        den  = lo_ohms - hi_ohms;
        gap  = lo_ohms - r_reg;
        gap5 = (ntc_r2t_pkg::GAP5_W'(gap) << 2) + ntc_r2t_pkg::GAP5_W'(gap);
        rem_init = REM_W'(gap5) << FRACTION_BITS;
        dsh_init = REM_W'(den) << (FRACTION_BITS + 2);
        rem_ge   = rem_reg >= dsh_reg;

        top_wide = TSW'(ntc_r2t_pkg::point_deg(IMW'(LAST_IDX))) << FRACTION_BITS;
        lo_wide  = TSW'(ntc_r2t_pkg::point_deg(IMW'(lo_reg))) << FRACTION_BITS;
        top_q    = OUT_W'(top_wide);
        lo_q     = OUT_W'(lo_wide);
    end

    assign s_ready = (ctrl.op == ntc_r2t_pkg::OP_LOAD);
    assign accept  = s_valid && s_ready;

    assign flags.no_in    = !s_valid;
    assign flags.le       = r_reg <= sel_ohms;
    assign flags.ge       = r_reg >= sel_ohms;
    assign flags.search   = ({1'b0, lo_reg} + 1'b1) < {1'b0, hi_reg};
    assign flags.flat     = lo_ohms <= hi_ohms;
    assign flags.div_more = cnt_reg != CNT_W'(1);
    assign flags.out_busy = m_valid_reg && !m_ready;

    // payload path
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            ntc_r2t_pkg::OP_LOAD: begin
                if (accept) begin
                    r_reg  <= s_resistance_ohms;
                    lo_reg <= '0;
                    hi_reg <= LAST_IDX;
                end
            end
            ntc_r2t_pkg::OP_SET_TOP: begin
                res_reg <= top_q;
            end
            ntc_r2t_pkg::OP_SET_ZERO: begin
                res_reg <= '0;
            end
            ntc_r2t_pkg::OP_HALVE: begin
                if (flags.search) begin
                    if (r_reg >= sel_ohms) begin
                        hi_reg <= mid;
                    end else begin
                        lo_reg <= mid;
                    end
                end
            end
            ntc_r2t_pkg::OP_PREP: begin
                res_reg <= lo_q;
                rem_reg <= rem_init;
                dsh_reg <= dsh_init;
                q_reg   <= '0;
                cnt_reg <= CNT_W'(QW);
            end
            ntc_r2t_pkg::OP_DIV: begin
                if (rem_ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                q_reg   <= {q_reg[QW-2:0], rem_ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            ntc_r2t_pkg::OP_SUM: begin
                res_reg <= res_reg + OUT_W'(q_reg);
            end
            ntc_r2t_pkg::OP_EMIT: begin
                if (!flags.out_busy) begin
                    m_temp_reg <= res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (ctrl.op == ntc_r2t_pkg::OP_EMIT && !flags.out_busy) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_temperature_q8 = m_temp_reg;

    // search bracket never collapses
    a_bracket: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == ntc_r2t_pkg::OP_HALVE) |-> (lo_reg < hi_reg))
        else $error("search bracket collapsed");

    // remainder stays below twice the shifted divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == ntc_r2t_pkg::OP_DIV) |-> ({1'b0, rem_reg} < {dsh_reg, 1'b0}))
        else $error("divider remainder out of range");

    // emit loads the output register with the staged result
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == ntc_r2t_pkg::OP_EMIT && !flags.out_busy)
        |=> (m_valid_reg && (m_temp_reg == $past(res_reg))))
        else $error("result not presented after emit");

endmodule

`default_nettype wire

FILE: src/ntc_resistance_to_temperature_core.sv
// ----------------------------------------------------------------------------
// ntc_resistance_to_temperature_core
// thermistor resistance to temperature by table search and interpolation
// ----------------------------------------------------------------------------
// One 16-bit resistance in ohms goes in, one temperature in unsigned fixed
// point (FRACTION_BITS fraction bits, truncated, low 15 bits) comes out, one
// transfer each way per item. A resistance at or below the last table entry
// gives the last point's temperature, one at or above the first entry gives
// zero; in between a binary search brackets the value and the block
// interpolates linearly. One item is in work at a time: a transfer in is taken
// only at the fetch step. The binary search makes at most
// ceil(log2(TABLE_ENTRIES - 1)) halving steps, and the restoring divider
// yields one quotient bit per cycle. A finished result waits in the output
// register while the next item is taken and worked on.
// ----------------------------------------------------------------------------
`default_nettype none

module ntc_resistance_to_temperature_core #(
    parameter int unsigned TABLE_ENTRIES = 21,  // 2 to 64 points
    parameter int unsigned FRACTION_BITS = 8    // 0 to 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input transfer
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [ntc_r2t_pkg::OHM_W-1:0]   s_resistance_ohms,
    // result transfer
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [ntc_r2t_pkg::OUT_W-1:0]        m_temperature_q8
);

    // control word from the microprogram, flags back from the datapath
    ntc_r2t_pkg::ctrl_t  ctrl;
    ntc_r2t_pkg::flags_t flags;

    // step counter and control store: fetch, range checks, search loop,
    // divider set-up, divide loop, final add, emit
    ntc_r2t_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    // bracket registers, table lookup, divider and output register
    ntc_r2t_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .ctrl              (ctrl),
        .flags             (flags),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_resistance_ohms (s_resistance_ohms),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_temperature_q8  (m_temperature_q8)
    );

endmodule

`default_nettype wire
